### sv/assert_macros.svh
// Assertion helpers included by the solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

### sv/qrs_pkg.sv
`default_nettype none
package qrs_pkg;
   localparam int COEF_W    = 16;
   localparam int FRAC      = 16;
   localparam int OUT_W     = 34;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int DISC_W    = PROD_W + 1;
   localparam int ROOT_W    = 33;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int REM_W     = ROOT_W + 3;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int NUM_W     = COEF_W + FRAC + 1;
   localparam int DIVD_W    = 33;
   localparam int DIVS_W    = COEF_W + 1;
   localparam int DREM_W    = DIVS_W + 1;
   localparam int DIV_STEPS = DIVD_W;

   localparam logic [1:0] KIND_TWO_REAL = 2'd0;
   localparam logic [1:0] KIND_DOUBLE   = 2'd1;
   localparam logic [1:0] KIND_COMPLEX  = 2'd2;
   localparam logic [1:0] KIND_DEGEN    = 2'd3;

   typedef struct packed {
      logic                     valid;
      logic [1:0]               kind;
      logic                     a_neg;
      logic                     opp;
      logic signed [NUM_W-1:0]  num;
      logic [DIVS_W-1:0]        den_mag;
   } meta_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic       neg1;
      logic       neg2;
   } tail_type;
endpackage
`default_nettype wire

### sv/qrs_divider.sv
`default_nettype none
module qrs_divider (
   input  wire logic                          clock,
   input  wire logic                          enable,
   input  wire logic [qrs_pkg::DIVD_W-1:0]    in_dividend,
   input  wire logic [qrs_pkg::DIVS_W-1:0]    in_divisor,
   output logic      [qrs_pkg::DIVD_W-1:0]    out_quotient
);
   // one restoring step per stage; dividend bits shift out as quotient bits shift in
   logic [qrs_pkg::DREM_W-1:0] rem_ff [1:qrs_pkg::DIV_STEPS];
   logic [qrs_pkg::DIVD_W-1:0] quo_ff [1:qrs_pkg::DIV_STEPS];
   logic [qrs_pkg::DIVS_W-1:0] dvs_ff [1:qrs_pkg::DIV_STEPS];
   logic [qrs_pkg::DREM_W-1:0] rem_at [0:qrs_pkg::DIV_STEPS];
   logic [qrs_pkg::DIVD_W-1:0] quo_at [0:qrs_pkg::DIV_STEPS];
   logic [qrs_pkg::DIVS_W-1:0] dvs_at [0:qrs_pkg::DIV_STEPS];

   assign rem_at[0] = '0;
   assign quo_at[0] = in_dividend;
   assign dvs_at[0] = in_divisor;

   for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_step
      logic [qrs_pkg::DREM_W-1:0] cur;
      logic [qrs_pkg::DREM_W-1:0] dvs_ext;
      logic                       ge;
      logic [qrs_pkg::DREM_W-1:0] rem_in;
      logic [qrs_pkg::DIVD_W-1:0] quo_in;

      always_comb begin
         cur     = {rem_at[k][qrs_pkg::DREM_W-2:0], quo_at[k][qrs_pkg::DIVD_W-1]};
         dvs_ext = {1'b0, dvs_at[k]};
         ge      = (cur >= dvs_ext);
         rem_in  = ge ? (cur - dvs_ext) : cur;
         quo_in  = {quo_at[k][qrs_pkg::DIVD_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            quo_ff[k+1] <= quo_in;
            dvs_ff[k+1] <= dvs_at[k];
         end
      end

      assign rem_at[k+1] = rem_ff[k+1];
      assign quo_at[k+1] = quo_ff[k+1];
      assign dvs_at[k+1] = dvs_ff[k+1];
   end

   assign out_quotient = quo_at[qrs_pkg::DIV_STEPS];
endmodule
`default_nettype wire

### sv/quadratic_root_solver.sv
// Path: stages 1 to 3, square root, dividend register, dividers, response register.
// Throughput: one transaction per cycle unless stalled; the square root (33 stages,
// one root bit each) and both dividers (33 stages, one quotient bit each) are fully pipelined.
// Back pressure: a stalled response freezes the whole pipeline in place.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
`default_nettype none
`include "assert_macros.svh"
module quadratic_root_solver (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_quadratic,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_linear,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_constant,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_root_kind,
   output logic signed [qrs_pkg::OUT_W-1:0]         rsp_first_value,
   output logic signed [qrs_pkg::OUT_W-1:0]         rsp_second_value
);
   // Global advance: every stage moves when the response register is free or
   // being taken. Bubbles travel as cleared valid bits.
   logic adv;
   logic rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // ---------------- stage 1: capture coefficients ----------------
   logic                               s1_valid_ff;
   logic signed [qrs_pkg::COEF_W-1:0]  s1_a_ff, s1_b_ff, s1_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff <= req_coef_quadratic;
         s1_b_ff <= req_coef_linear;
         s1_c_ff <= req_coef_constant;
      end
   end

   // ---------------- stage 2: magnitudes and products ----------------
   logic [qrs_pkg::COEF_W-1:0]        a_mag, b_mag, c_mag;
   logic signed [qrs_pkg::NUM_W-1:0]  b_ext;
   qrs_pkg::meta_type                 s2_meta_in;
   qrs_pkg::meta_type                 s2_meta_ff;
   logic [qrs_pkg::PROD_W-1:0]        s2_bb_ff, s2_ac_ff;

   always_comb begin
      // two's complement magnitude; the most negative value maps to itself unsigned
      a_mag = s1_a_ff[qrs_pkg::COEF_W-1] ? (~s1_a_ff + 1'b1) : s1_a_ff;
      b_mag = s1_b_ff[qrs_pkg::COEF_W-1] ? (~s1_b_ff + 1'b1) : s1_b_ff;
      c_mag = s1_c_ff[qrs_pkg::COEF_W-1] ? (~s1_c_ff + 1'b1) : s1_c_ff;
      b_ext = qrs_pkg::NUM_W'(s1_b_ff);

      s2_meta_in.valid   = s1_valid_ff;
      s2_meta_in.kind    = (s1_a_ff == '0) ? qrs_pkg::KIND_DEGEN : qrs_pkg::KIND_TWO_REAL;
      s2_meta_in.a_neg   = s1_a_ff[qrs_pkg::COEF_W-1];
      // opposite signs of a and c make -4ac positive, so d is a plain sum
      s2_meta_in.opp     = (s1_c_ff != '0) &&
                           (s1_a_ff[qrs_pkg::COEF_W-1] != s1_c_ff[qrs_pkg::COEF_W-1]);
      s2_meta_in.num     = -(b_ext <<< qrs_pkg::FRAC);
      s2_meta_in.den_mag = {a_mag, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_meta_ff.valid <= 1'b0;
      end else if (adv) begin
         s2_meta_ff.valid <= s2_meta_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_meta_ff.kind    <= s2_meta_in.kind;
         s2_meta_ff.a_neg   <= s2_meta_in.a_neg;
         s2_meta_ff.opp     <= s2_meta_in.opp;
         s2_meta_ff.num     <= s2_meta_in.num;
         s2_meta_ff.den_mag <= s2_meta_in.den_mag;
         s2_bb_ff           <= b_mag * b_mag;
         s2_ac_ff           <= a_mag * c_mag;
      end
   end

   // ---------------- stage 3: discriminant and root kind ----------------
   localparam int DW = qrs_pkg::PROD_W + 3;
   logic [DW-1:0]                 ac4, d_sum, d_dif, d_dif_mag;
   logic [qrs_pkg::DISC_W-1:0]    d_mag;
   qrs_pkg::meta_type             s3_meta_in;

   always_comb begin
      ac4       = {1'b0, s2_ac_ff, 2'b00};
      d_sum     = {3'b000, s2_bb_ff} + ac4;
      d_dif     = {3'b000, s2_bb_ff} - ac4;
      d_dif_mag = d_dif[DW-1] ? (~d_dif + 1'b1) : d_dif;
      d_mag     = s2_meta_ff.opp ? d_sum[qrs_pkg::DISC_W-1:0]
                                 : d_dif_mag[qrs_pkg::DISC_W-1:0];
      s3_meta_in = s2_meta_ff;
      if (s2_meta_ff.kind == qrs_pkg::KIND_DEGEN) begin
         s3_meta_in.kind = qrs_pkg::KIND_DEGEN;
      end else if (s2_meta_ff.opp) begin
         s3_meta_in.kind = qrs_pkg::KIND_TWO_REAL;
      end else if (d_dif == '0) begin
         s3_meta_in.kind = qrs_pkg::KIND_DOUBLE;
      end else if (d_dif[DW-1]) begin
         s3_meta_in.kind = qrs_pkg::KIND_COMPLEX;
      end else begin
         s3_meta_in.kind = qrs_pkg::KIND_TWO_REAL;
      end
   end

   // ---------------- square root pipeline ----------------
   // Radicand is |d| * 2^(2*FRAC); one root bit resolved per stage.
   // Index 0 is the stage 3 register.
   logic [qrs_pkg::REM_W-1:0]   sq_rem_ff  [0:qrs_pkg::SQ_STEPS];
   logic [qrs_pkg::ROOT_W-1:0]  sq_root_ff [0:qrs_pkg::SQ_STEPS];
   logic [qrs_pkg::RAD_W-1:0]   sq_rad_ff  [0:qrs_pkg::SQ_STEPS];
   qrs_pkg::meta_type           sq_meta_ff [0:qrs_pkg::SQ_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_meta_ff[0].valid <= 1'b0;
      end else if (adv) begin
         sq_meta_ff[0].valid <= s3_meta_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_meta_ff[0].kind    <= s3_meta_in.kind;
         sq_meta_ff[0].a_neg   <= s3_meta_in.a_neg;
         sq_meta_ff[0].opp     <= s3_meta_in.opp;
         sq_meta_ff[0].num     <= s3_meta_in.num;
         sq_meta_ff[0].den_mag <= s3_meta_in.den_mag;
         sq_rem_ff[0]          <= '0;
         sq_root_ff[0]         <= '0;
         sq_rad_ff[0]          <= qrs_pkg::RAD_W'({d_mag, {(2 * qrs_pkg::FRAC){1'b0}}});
      end
   end

   for (genvar k = 0; k < qrs_pkg::SQ_STEPS; k++) begin : g_sqrt
      logic [qrs_pkg::REM_W-1:0]  cur, trial, rem_in;
      logic                       ge;

      always_comb begin
         // bring down the next two radicand bits and try a 1 in this root position
         cur    = {sq_rem_ff[k][qrs_pkg::REM_W-3:0], sq_rad_ff[k][qrs_pkg::RAD_W-1 -: 2]};
         trial  = qrs_pkg::REM_W'({sq_root_ff[k], 2'b01});
         ge     = (cur >= trial);
         rem_in = ge ? (cur - trial) : cur;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_meta_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            sq_meta_ff[k+1].valid <= sq_meta_ff[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_meta_ff[k+1].kind    <= sq_meta_ff[k].kind;
            sq_meta_ff[k+1].a_neg   <= sq_meta_ff[k].a_neg;
            sq_meta_ff[k+1].opp     <= sq_meta_ff[k].opp;
            sq_meta_ff[k+1].num     <= sq_meta_ff[k].num;
            sq_meta_ff[k+1].den_mag <= sq_meta_ff[k].den_mag;
            sq_rem_ff[k+1]          <= rem_in;
            sq_root_ff[k+1]         <= {sq_root_ff[k][qrs_pkg::ROOT_W-2:0], ge};
            sq_rad_ff[k+1]          <= {sq_rad_ff[k][qrs_pkg::RAD_W-3:0], 2'b00};
         end
      end
   end

   // ---------------- dividend selection ----------------
   localparam int SW = qrs_pkg::NUM_W + 2;
   qrs_pkg::meta_type                sq_last;
   logic signed [SW-1:0]             num_w, root_w, n_plus, n_minus, sel1, sel2;
   logic [SW-1:0]                    mag1, mag2;
   qrs_pkg::tail_type                pr_tail_in;
   qrs_pkg::tail_type                pr_tail_ff;
   logic [qrs_pkg::DIVD_W-1:0]       pr_divd1_ff, pr_divd2_ff;
   logic [qrs_pkg::DIVS_W-1:0]       pr_dvs_ff;

   assign sq_last = sq_meta_ff[qrs_pkg::SQ_STEPS];

   always_comb begin
      num_w   = SW'(sq_last.num);
      root_w  = SW'({1'b0, sq_root_ff[qrs_pkg::SQ_STEPS]});
      n_plus  = num_w + root_w;
      n_minus = num_w - root_w;
      case (sq_last.kind)
         qrs_pkg::KIND_TWO_REAL: begin
            sel1 = n_plus;
            sel2 = n_minus;
         end
         qrs_pkg::KIND_COMPLEX: begin
            sel1 = num_w;
            sel2 = root_w;
         end
         default: begin
            sel1 = num_w;
            sel2 = num_w;
         end
      endcase
      mag1 = sel1[SW-1] ? (~sel1 + 1'b1) : sel1;
      mag2 = sel2[SW-1] ? (~sel2 + 1'b1) : sel2;
      pr_tail_in.valid = sq_last.valid;
      pr_tail_in.kind  = sq_last.kind;
      pr_tail_in.neg1  = sel1[SW-1] ^ sq_last.a_neg;
      // the imaginary magnitude divides by |2a| and stays non-negative
      pr_tail_in.neg2  = (sq_last.kind == qrs_pkg::KIND_COMPLEX) ? 1'b0
                                                                 : (sel2[SW-1] ^ sq_last.a_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pr_tail_ff.valid <= 1'b0;
      end else if (adv) begin
         pr_tail_ff.valid <= pr_tail_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pr_tail_ff.kind <= pr_tail_in.kind;
         pr_tail_ff.neg1 <= pr_tail_in.neg1;
         pr_tail_ff.neg2 <= pr_tail_in.neg2;
         pr_divd1_ff     <= mag1[qrs_pkg::DIVD_W-1:0];
         pr_divd2_ff     <= mag2[qrs_pkg::DIVD_W-1:0];
         pr_dvs_ff       <= sq_last.den_mag;
      end
   end

   // ---------------- dividers and aligned side pipeline ----------------
   logic [qrs_pkg::DIVD_W-1:0] quo1, quo2;

   qrs_divider u_div_first (
      .clock        (clock),
      .enable       (adv),
      .in_dividend  (pr_divd1_ff),
      .in_divisor   (pr_dvs_ff),
      .out_quotient (quo1)
   );

   qrs_divider u_div_second (
      .clock        (clock),
      .enable       (adv),
      .in_dividend  (pr_divd2_ff),
      .in_divisor   (pr_dvs_ff),
      .out_quotient (quo2)
   );

   qrs_pkg::tail_type tl_ff [1:qrs_pkg::DIV_STEPS];
   qrs_pkg::tail_type tl_at [0:qrs_pkg::DIV_STEPS];

   assign tl_at[0] = pr_tail_ff;

   for (genvar k = 0; k < qrs_pkg::DIV_STEPS; k++) begin : g_tail
      always_ff @(posedge clock) begin
         if (reset) begin
            tl_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            tl_ff[k+1].valid <= tl_at[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            tl_ff[k+1].kind <= tl_at[k].kind;
            tl_ff[k+1].neg1 <= tl_at[k].neg1;
            tl_ff[k+1].neg2 <= tl_at[k].neg2;
         end
      end

      assign tl_at[k+1] = tl_ff[k+1];
   end

   // ---------------- response register ----------------
   qrs_pkg::tail_type                   tl_last;
   logic signed [qrs_pkg::OUT_W-1:0]    q1_ext, q2_ext, first_in, second_in;
   logic [1:0]                          rsp_kind_ff;
   logic signed [qrs_pkg::OUT_W-1:0]    rsp_first_ff, rsp_second_ff;

   assign tl_last = tl_at[qrs_pkg::DIV_STEPS];

   always_comb begin
      q1_ext = qrs_pkg::OUT_W'({1'b0, quo1});
      q2_ext = qrs_pkg::OUT_W'({1'b0, quo2});
      if (tl_last.kind == qrs_pkg::KIND_DEGEN) begin
         // drop the quotients; a zero divisor makes them meaningless
         first_in  = '0;
         second_in = '0;
      end else begin
         first_in  = tl_last.neg1 ? -q1_ext : q1_ext;
         second_in = tl_last.neg2 ? -q2_ext : q2_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= tl_last.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_kind_ff   <= tl_last.kind;
         rsp_first_ff  <= first_in;
         rsp_second_ff <= second_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_root_kind    = rsp_kind_ff;
   assign rsp_first_value  = rsp_first_ff;
   assign rsp_second_value = rsp_second_ff;

   // ---------------- assertions ----------------
   `ASSERT_IMPLIES(a_degen_zero, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == qrs_pkg::KIND_DEGEN),
      (rsp_first_ff == '0) && (rsp_second_ff == '0))
   `ASSERT_IMPLIES(a_complex_nonneg, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == qrs_pkg::KIND_COMPLEX),
      !rsp_second_ff[qrs_pkg::OUT_W-1])
   `ASSERT_IMPLIES(a_double_equal, clock, reset,
      rsp_valid_ff && (rsp_kind_ff == qrs_pkg::KIND_DOUBLE),
      rsp_first_ff == rsp_second_ff)
   `ASSERT_IMPLIES(a_stall_only_backpressure, clock, reset,
      req_stall, rsp_valid_ff && rsp_stall)
endmodule
`default_nettype wire

### test/quadratic_root_solver_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_solver_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_quadratic,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_linear,
   input  wire logic signed [qrs_pkg::COEF_W-1:0]   req_coef_constant,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [1:0]                          rsp_root_kind,
   input  wire logic signed [qrs_pkg::OUT_W-1:0]    rsp_first_value,
   input  wire logic signed [qrs_pkg::OUT_W-1:0]    rsp_second_value,
   output int                                       error_count,
   output int                                       roots_pending,
   output int                                       roots_checked,
   output int                                       kind_seen [4]
);
   typedef struct {
      logic [1:0]                       kind;
      logic signed [qrs_pkg::OUT_W-1:0] first;
      logic signed [qrs_pkg::OUT_W-1:0] second;
   } roots_type;

   roots_type expected_roots [$];

   function automatic logic [63:0] floor_sqrt(logic [127:0] radicand);
      logic [63:0]  root;
      logic [63:0]  trial;
      logic [127:0] square;
      root = '0;
      for (int i = 63; i >= 0; i--) begin
         trial  = root | (64'd1 << i);
         square = {64'd0, trial} * {64'd0, trial};
         if (square <= radicand) root = trial;
      end
      return root;
   endfunction

   function automatic logic signed [qrs_pkg::OUT_W-1:0] clamp_out(longint value);
      longint top_value;
      top_value = (longint'(1) <<< (qrs_pkg::OUT_W - 1)) - 1;
      if (value > top_value) value = top_value;
      if (value < -top_value - 1) value = -top_value - 1;
      return value[qrs_pkg::OUT_W-1:0];
   endfunction

   function automatic roots_type solve_roots(logic signed [qrs_pkg::COEF_W-1:0] qa,
                                             logic signed [qrs_pkg::COEF_W-1:0] qb,
                                             logic signed [qrs_pkg::COEF_W-1:0] qc);
      roots_type   res;
      longint      a, b, c, disc, num, den, root, first, second;
      logic [127:0] radicand;
      a = qa;
      b = qb;
      c = qc;
      if (a == 0) begin
         res.kind   = qrs_pkg::KIND_DEGEN;
         res.first  = '0;
         res.second = '0;
         return res;
      end
      disc = b * b - 4 * a * c;
      num  = -b * (longint'(1) <<< qrs_pkg::FRAC);
      den  = 2 * a;
      if (disc == 0) begin
         first  = num / den;
         second = first;
         res.kind = qrs_pkg::KIND_DOUBLE;
      end else begin
         radicand = {64'd0, (disc > 0 ? disc : -disc)} << (2 * qrs_pkg::FRAC);
         root = longint'(floor_sqrt(radicand));
         if (disc > 0) begin
            first    = (num + root) / den;
            second   = (num - root) / den;
            res.kind = qrs_pkg::KIND_TWO_REAL;
         end else begin
            first    = num / den;
            second   = root / (den < 0 ? -den : den);
            res.kind = qrs_pkg::KIND_COMPLEX;
         end
      end
      res.first  = clamp_out(first);
      res.second = clamp_out(second);
      return res;
   endfunction

   initial begin
      error_count   = 0;
      roots_checked = 0;
      roots_pending = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
   end

   always @(posedge clock) begin
      roots_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_roots.push_back(solve_roots(req_coef_quadratic, req_coef_linear,
                                                 req_coef_constant));
         if (rsp_valid && !rsp_stall) begin
            if (expected_roots.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = expected_roots.pop_front();
               roots_checked++;
               kind_seen[want.kind]++;
               if (rsp_root_kind !== want.kind) begin
                  $error("root_kind: expected %0d, actual %0d", want.kind, rsp_root_kind);
                  error_count++;
               end
               if (rsp_first_value !== want.first) begin
                  $error("first_value: expected %0d, actual %0d", want.first,
                         rsp_first_value);
                  error_count++;
               end
               if (rsp_second_value !== want.second) begin
                  $error("second_value: expected %0d, actual %0d", want.second,
                         rsp_second_value);
                  error_count++;
               end
            end
         end
      end
      roots_pending = expected_roots.size();
   end
endmodule
`default_nettype wire

### test/quadratic_root_solver_test.sv
`timescale 1ns / 100ps
`default_nettype none
module quadratic_root_solver_test;
   typedef logic signed [qrs_pkg::COEF_W-1:0] coef_type;

   localparam int RANDOM_COUNT = 530;
   localparam int IDLE_LIMIT   = 5000;   // cycles without any transaction
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
   localparam int DRAIN_CYCLES = 100;    // beyond the pipeline latency

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [qrs_pkg::COEF_W-1:0]  req_coef_quadratic = '0;
   logic signed [qrs_pkg::COEF_W-1:0]  req_coef_linear = '0;
   logic signed [qrs_pkg::COEF_W-1:0]  req_coef_constant = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic [1:0]                         rsp_root_kind;
   logic signed [qrs_pkg::OUT_W-1:0]   rsp_first_value;
   logic signed [qrs_pkg::OUT_W-1:0]   rsp_second_value;

   int error_count, roots_pending, roots_checked;
   int kind_seen [4];
   int sets_sent = 0;
   int idle_cycles = 0;
   bit stimulus_done = 1'b0;

   quadratic_root_solver i_dut (.*);

   quadratic_root_solver_checker i_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Send one coefficient set; keep valid high so bursts run back to back.
   task automatic send_coefficients(logic signed [qrs_pkg::COEF_W-1:0] qa,
                                    logic signed [qrs_pkg::COEF_W-1:0] qb,
                                    logic signed [qrs_pkg::COEF_W-1:0] qc);
      req_valid          <= 1'b1;
      req_coef_quadratic <= qa;
      req_coef_linear    <= qb;
      req_coef_constant  <= qc;
      do @(posedge clock); while (req_stall);
      sets_sent++;
   endtask

   task automatic idle_gap(int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Random set: full-range values, plus double roots, small values, a of +1 or -1 and a = 0.
   task automatic send_random_set();
      int pick, m, n;
      logic signed [qrs_pkg::COEF_W-1:0] qa, qb, qc;
      pick = $urandom_range(0, 9);
      qa = coef_type'($urandom());
      qb = coef_type'($urandom());
      qc = coef_type'($urandom());
      case (pick)
         0: begin
            qa = '0;
         end
         1, 2: begin
            // build b*b == 4ac for a double root
            m  = $urandom_range(1, 127);
            n  = $urandom_range(0, 127);
            qa = coef_type'(($urandom_range(0, 1) != 0) ? m * m : -(m * m));
            qc = coef_type'((qa < 0) ? -(n * n) : n * n);
            qb = coef_type'(($urandom_range(0, 1) != 0) ? 2 * m * n : -2 * m * n);
         end
         3, 4: begin
            qa = coef_type'(int'($urandom_range(0, 14)) - 7);
            qb = coef_type'(int'($urandom_range(0, 40)) - 20);
            qc = coef_type'(int'($urandom_range(0, 40)) - 20);
            if (qa == 0) qa = 1;
         end
         5: begin
            // tiny a with big b drives roots toward saturation
            qa = coef_type'(($urandom_range(0, 1) != 0) ? 1 : -1);
         end
         default: ;
      endcase
      send_coefficients(qa, qb, qc);
   endtask

   // Stimulus: directed sets, then random bursts, most of them separated by gaps.
   initial begin
      int burst;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_coefficients(0, 5, 7);                 // degenerate
      send_coefficients(0, -32768, 32767);        // degenerate with extremes
      send_coefficients(1, -3, 2);                // two real roots
      send_coefficients(-2, 0, 8);                // real roots, negative a
      send_coefficients(1, 2, 1);                 // double root
      send_coefficients(16384, -32768, 16384);    // double root at the extremes
      send_coefficients(-1, 0, 0);                // double root at zero
      send_coefficients(1, 0, 1);                 // complex pair
      send_coefficients(-3, 2, -5);               // complex, negative a
      send_coefficients(32767, 32767, 32767);     // all maximum
      send_coefficients(-32768, -32768, -32768);  // all minimum
      send_coefficients(-32768, 32767, 32767);
      send_coefficients(32767, -32768, -32768);
      send_coefficients(1, -32768, -32768);       // largest roots
      send_coefficients(-1, 32767, 32767);
      send_coefficients(1, 32767, 0);
      send_coefficients(-32768, 0, 32767);        // roots near plus and minus one
      send_coefficients(7, 1, -1);                // inexact square root
      send_coefficients(-5, -1, 3);
      idle_gap($urandom_range(1, 5));
      for (int i = 0; i < RANDOM_COUNT; ) begin
         burst = $urandom_range(1, 20);
         for (int j = 0; j < burst && i < RANDOM_COUNT; j++, i++) send_random_set();
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 12));
      end
      req_valid <= 1'b0;
      wait (roots_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      stimulus_done = 1'b1;
   end

   // Receiver: random stall pattern, stretches of no stall, and one long hold-off.
   initial begin
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && sets_sent >= 150) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         case ((sets_sent / 64) % 3)
            0: rsp_stall <= ($urandom_range(0, 3) == 0);
            1: rsp_stall <= 1'b0;
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   // Verdict: normal end or timeout.
   initial begin
      wait (stimulus_done || idle_cycles >= IDLE_LIMIT);
      if (stimulus_done) begin
         $display("Checked %0d result sets from %0d coefficient sets:", roots_checked,
                  sets_sent);
         $display("  %0d two real, %0d double, %0d complex, %0d with a at zero",
                  kind_seen[qrs_pkg::KIND_TWO_REAL], kind_seen[qrs_pkg::KIND_DOUBLE],
                  kind_seen[qrs_pkg::KIND_COMPLEX], kind_seen[qrs_pkg::KIND_DEGEN]);
         if (error_count == 0 && roots_pending == 0) begin
            $display("Verification passed");
         end else begin
            $display("Verification failed");
         end
      end else begin
         $error("timeout after %0d idle cycles, %0d results outstanding", idle_cycles,
                roots_pending);
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
